[src/upa_pkg.sv]
// Shared types and constants for the alpha unpremultiply block.
// No dependencies.
package upa_pkg;

    localparam int unsigned CH_W = 8;
    localparam int unsigned RECIP_W = 24;
    localparam int unsigned PROD_W = 32;
    localparam int unsigned LUT_DEPTH = 1 << CH_W;

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(32'h8000);
    localparam int unsigned RECIP_NUM = 255 * 65536;
    localparam logic [CH_W-1:0] BYTE_MAX = CH_W'(255);
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = BYTE_MAX;
    localparam logic [CH_W-1:0] ALPHA_CLEAR = '0;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] alpha;
        logic            last;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            done;
        logic            translucent;
    } t_result;

endpackage

[src/unpremultiply_alpha_bgra_to_rgba.sv]
// Premultiplied BGRA to straight RGBA, one pixel per beat.
// Each input beat passes through the input register, then the result register.
// Throughput: 1 pixel per cycle while the output is not stalled; the stage is one table lookup and an 8x24 multiply.
// Reset (synchronous, active low) empties both stages and clears the translucency flag.
// Depends on upa_pkg and upa_core.
module unpremultiply_alpha_bgra_to_rgba
    import upa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [CH_W-1:0] i_in_blue,
    input  logic [CH_W-1:0] i_in_green,
    input  logic [CH_W-1:0] i_in_red,
    input  logic [CH_W-1:0] i_in_alpha,
    input  logic            i_frame_last,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CH_W-1:0] o_out_red,
    output logic [CH_W-1:0] o_out_green,
    output logic [CH_W-1:0] o_out_blue,
    output logic [CH_W-1:0] o_out_alpha,
    output logic            o_frame_done,
    output logic            o_frame_translucent
);

    logic    r_s1_valid;
    t_pixel  r_s1;
    logic    r_s2_valid;
    t_result r_s2;
    logic    r_seen;

    t_result w_res;
    logic    n_seen;
    logic    w_s2_adv;
    logic    w_s1_adv;
    logic    w_xfer;

    assign w_s2_adv = ~r_s2_valid | ~i_stall;
    assign w_s1_adv = ~r_s1_valid | w_s2_adv;
    assign w_xfer   = r_s1_valid & w_s2_adv;
    assign o_stall  = ~w_s1_adv;

    upa_core u_core (
        .i_pix      (r_s1),
        .i_seen     (r_seen),
        .o_res      (w_res),
        .o_seen_nxt (n_seen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_seen     <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_xfer) begin
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_valid) begin
            r_s1.blue  <= i_in_blue;
            r_s1.green <= i_in_green;
            r_s1.red   <= i_in_red;
            r_s1.alpha <= i_in_alpha;
            r_s1.last  <= i_frame_last;
        end
        if (w_xfer) begin
            r_s2 <= w_res;
        end
    end

    assign o_valid             = r_s2_valid;
    assign o_out_red           = r_s2.red;
    assign o_out_green         = r_s2.green;
    assign o_out_blue          = r_s2.blue;
    assign o_out_alpha         = r_s2.alpha;
    assign o_frame_done        = r_s2.done;
    assign o_frame_translucent = r_s2.translucent;

`ifndef SYNTHESIS
    a_translucent_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> !o_frame_translucent)
        else $error("translucent flag outside frame end");

    a_flag_cleared_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && r_s1.last) |=> !r_seen)
        else $error("translucency flag not cleared after frame end");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && !r_s1.last && (r_s1.alpha != ALPHA_OPAQUE)) |=> r_seen)
        else $error("translucent pixel not recorded");

    a_clear_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_alpha == ALPHA_CLEAR)) |->
        ((o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0)))
        else $error("transparent pixel with colour");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");
`endif

endmodule

[src/upa_core.sv]
// Per-pixel unpremultiply: reciprocal table, channel scaling with saturation,
// channel reorder and translucency tracking. Depends on upa_pkg.
module upa_core
    import upa_pkg::*;
(
    input  t_pixel  i_pix,
    input  logic    i_seen,
    output t_result o_res,
    output logic    o_seen_nxt
);

    logic [RECIP_W-1:0] w_recip_tab [0:LUT_DEPTH-1];
    logic [RECIP_W-1:0] w_inv;
    logic               w_opaque;
    logic               w_clear;
    logic               w_seen;

    // round(255 * 65536 / a); entry for zero alpha is never used
    assign w_recip_tab[0] = '0;
    for (genvar a = 1; a < LUT_DEPTH; a++) begin : g_recip
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((RECIP_NUM + a / 2) / a);
        assign w_recip_tab[a] = RECIP;
    end

    function automatic logic [CH_W-1:0] scale_chan(
        input logic [CH_W-1:0]    c,
        input logic [RECIP_W-1:0] inv
    );
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] sum;
        logic [15:0]       q;
        prod = PROD_W'(c) * PROD_W'(inv);
        sum  = prod + RND_HALF;
        q    = sum[PROD_W-1:16];
        return (q > 16'(BYTE_MAX)) ? BYTE_MAX : q[CH_W-1:0];
    endfunction

    assign w_inv    = w_recip_tab[i_pix.alpha];
    assign w_opaque = (i_pix.alpha == ALPHA_OPAQUE);
    assign w_clear  = (i_pix.alpha == ALPHA_CLEAR);
    assign w_seen   = i_seen | ~w_opaque;

    always_comb begin
        if (w_opaque) begin
            o_res.red   = i_pix.red;
            o_res.green = i_pix.green;
            o_res.blue  = i_pix.blue;
        end else if (w_clear) begin
            o_res.red   = '0;
            o_res.green = '0;
            o_res.blue  = '0;
        end else begin
            o_res.red   = scale_chan(i_pix.red, w_inv);
            o_res.green = scale_chan(i_pix.green, w_inv);
            o_res.blue  = scale_chan(i_pix.blue, w_inv);
        end
        o_res.alpha       = i_pix.alpha;
        o_res.done        = i_pix.last;
        o_res.translucent = i_pix.last & w_seen;
    end

    // flag clears once the frame end has been reported
    assign o_seen_nxt = w_seen & ~i_pix.last;

endmodule
